[src/wbs_pkg.sv]
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared constants and types for the weighted bin selection core.
// ----------------------------------------------------------------------------
`default_nettype none

package wbs_pkg;

  localparam int BINS        = 64;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_W   = $clog2(BINS);
  localparam int CNT_W   = $clog2(BINS + 1);
  localparam int SUM_W   = WEIGHT_BITS + IDX_W;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = SUM_W + FRAC_W;
  localparam int CFG_W   = 7;
  localparam int BIN_F_W = 6;
  localparam int WGT_F_W = 16;
  localparam int SEL_W   = 6;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  typedef struct packed {
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [IDX_W-1:0]       rd_addr;
  } mem_req_t;

endpackage

`default_nettype wire

[src/wbs_if.sv]
// ----------------------------------------------------------------------------
// wbs_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbs_in_if
  import wbs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               command;
  logic [BIN_F_W-1:0] bin_index;
  logic [WGT_F_W-1:0] weight;
  logic [FRAC_W-1:0]  random_fraction;

  modport source (
    output valid, command, bin_index, weight, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, command, bin_index, weight, random_fraction,
    output ready
  );
endinterface

interface wbs_out_if
  import wbs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEL_W-1:0] selected_bin;

  modport source (output valid, selected_bin, input ready);
  modport sink   (input valid, selected_bin, output ready);
endinterface

`default_nettype wire

[src/wbs_ram.sv]
// ----------------------------------------------------------------------------
// wbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/wbs_engine.sv]
// ----------------------------------------------------------------------------
// wbs_engine
// Draw sequencer: total pass, threshold multiply, cumulative scan pass; also issues weight writes.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_engine
  import wbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  wbs_in_if.sink                      in_ch,
  wbs_out_if.source                   out_ch,
  input  wire logic [CFG_W-1:0]       active_bins,
  output      mem_req_t               mem_req,
  input  wire logic [WEIGHT_BITS-1:0] rd_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   dat_idx_r, dat_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   res_r, res_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]   thr_r, thr_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;

  logic               in_fire;
  logic [CNT_W-1:0]   cnt_in;
  logic               issue;
  logic [SUM_W-1:0]   run_sum;
  logic [PROD_W-1:0]  prod;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.selected_bin = sel_r;

  always_comb begin
    if (active_bins == '0) begin
      cnt_in = CNT_W'(1);
    end else if (32'(active_bins) > BINS) begin
      cnt_in = CNT_W'(BINS);
    end else begin
      cnt_in = CNT_W'(active_bins);
    end
  end

  assign run_sum = acc_r + SUM_W'(rd_data);
  assign prod    = PROD_W'(acc_r) * PROD_W'(frac_r);

  always_comb begin
    if (state_r == ST_SCAN) begin
      issue = ({1'b0, idx_r} + (CNT_W+1)'(1)) < {1'b0, cnt_r};
    end else begin
      issue = (state_r == ST_SUM) && (idx_r < cnt_r);
    end
  end

  always_comb begin
    mem_req.wr_en   = in_fire && (in_ch.command == CMD_WRITE) &&
                      (32'(in_ch.bin_index) < BINS);
    mem_req.wr_addr = IDX_W'(in_ch.bin_index);
    mem_req.wr_data = WEIGHT_BITS'(in_ch.weight);
    mem_req.rd_addr = IDX_W'(idx_r);
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    dat_idx_nxt   = dat_idx_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    acc_nxt       = acc_r;
    thr_nxt       = thr_r;
    frac_nxt      = frac_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.command == CMD_DRAW)) begin
          frac_nxt  = in_ch.random_fraction;
          cnt_nxt   = cnt_in;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          acc_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        pend_nxt = issue;
        if (issue) begin
          idx_nxt     = idx_r + CNT_W'(1);
          dat_idx_nxt = idx_r;
        end
        if (pend_r) begin
          acc_nxt = run_sum;
        end
        if (!issue && !pend_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        thr_nxt   = prod[PROD_W-1:FRAC_W];
        acc_nxt   = '0;
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          idx_nxt     = idx_r + CNT_W'(1);
          dat_idx_nxt = idx_r;
        end
        if (pend_r) begin
          acc_nxt = run_sum;
        end
        if (pend_r && (run_sum > thr_r)) begin
          res_nxt   = dat_idx_r;
          state_nxt = ST_DONE;
        end else if (!pend_r && !issue) begin
          res_nxt   = cnt_r - CNT_W'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          sel_nxt       = SEL_W'(res_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    dat_idx_r <= dat_idx_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    acc_r     <= acc_nxt;
    thr_r     <= thr_nxt;
    frac_r    <= frac_nxt;
    sel_r     <= sel_nxt;
  end

endmodule

`default_nettype wire

[src/weighted_bin_selection_core.sv]
// Write beat: no result; the next beat can be taken the cycle after.
// Draw beat over n active bins: a total pass, a threshold multiply, a scan pass that
// stops at the first bin whose running sum exceeds the threshold, then a load of the
// output register, held off by any output stall; the next beat can be taken the cycle after.
// Both passes go through the single weight RAM read port, one weight per cycle.
// Reset (sync, active low): weights read as zero via per-bin valid bits; active_bins = 1.
// ----------------------------------------------------------------------------
// weighted_bin_selection_core
// Roulette-wheel bin selection over a RAM of bin weights.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_bin_selection_core
  import wbs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  wbs_in_if.sink                in_ch,
  wbs_out_if.source             out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0]       active_bins_r;
  logic [BINS-1:0]        vld_r;
  logic                   vld_q_r;
  mem_req_t               mem_req;
  logic [WEIGHT_BITS-1:0] ram_rdata;
  logic [WEIGHT_BITS-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_bins_r <= CFG_W'(1);
      vld_r         <= '0;
      vld_q_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_bins_r <= cfg_wr_data;
      end
      if (mem_req.wr_en) begin
        vld_r[mem_req.wr_addr] <= 1'b1;
      end
      vld_q_r <= vld_r[mem_req.rd_addr];
    end
  end

  assign rd_data = vld_q_r ? ram_rdata : '0;

  wbs_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.wr_en),
    .waddr (mem_req.wr_addr),
    .wdata (mem_req.wr_data),
    .raddr (mem_req.rd_addr),
    .rdata (ram_rdata)
  );

  wbs_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .active_bins (active_bins_r),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

`ifndef SYNTHESIS
  a_reset_clears_weights: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("weight valid bits not cleared by reset");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |=> vld_r[$past(mem_req.wr_addr)])
    else $error("written bin not marked valid");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.command == CMD_WRITE)) |=> !$rose(out_ch.valid))
    else $error("write beat produced a result beat");
`endif

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for weighted_bin_selection_core. Weight writes and
// draws go in over the input channel from a queue of pending beats; a local
// roulette-wheel predictor tracks the weight table and active bin count and
// queues the expected bin for each accepted draw. Each result beat is checked
// against the oldest prediction. Phases run over several active bin counts,
// with random stalls on both channels and one phase with none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wbs_pkg::*;

  typedef struct {
    logic               command;
    logic [BIN_F_W-1:0] bin_index;
    logic [WGT_F_W-1:0] weight;
    logic [FRAC_W-1:0]  random_fraction;
  } beat_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  wbs_in_if  in_bus ();
  wbs_out_if out_bus ();

  weighted_bin_selection_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [WEIGHT_BITS-1:0] weight_table [BINS] = '{default: '0};
  logic [CFG_W-1:0]       active_cfg = CFG_W'(1);
  logic [SEL_W-1:0]       predicted_bins [$];
  beat_t                  pending_beats [$];
  beat_t                  held_beat;
  logic [SEL_W-1:0]       due_bin;
  int unsigned            beats_queued = 0;
  int unsigned            beats_taken = 0;
  int unsigned            failures = 0;
  bit                     no_stall = 1'b0;

  always #5 clk = ~clk;

  function automatic int unsigned live_bins();
    if (active_cfg == 0) return 1;
    if (active_cfg > BINS) return BINS;
    return active_cfg;
  endfunction

  function automatic logic [SEL_W-1:0] roulette_pick(input logic [FRAC_W-1:0] frac);
    int unsigned      n;
    int unsigned      i;
    longint unsigned  total;
    longint unsigned  threshold;
    longint unsigned  run;
    logic [SEL_W-1:0] chosen;
    bit               found;
    n = live_bins();
    total = 0;
    run = 0;
    found = 1'b0;
    for (i = 0; i < n; i++) total += weight_table[i];
    threshold = (total * frac) >> 16;
    chosen = SEL_W'(n - 1);
    for (i = 0; i + 1 < n; i++) begin
      run += weight_table[i];
      if (!found && run > threshold) begin
        chosen = SEL_W'(i);
        found = 1'b1;
      end
    end
    return chosen;
  endfunction

  task automatic queue_write(input logic [BIN_F_W-1:0] idx, input logic [WGT_F_W-1:0] w);
    beat_t b;
    b.command = CMD_WRITE;
    b.bin_index = idx;
    b.weight = w;
    b.random_fraction = FRAC_W'($urandom);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_draw(input logic [FRAC_W-1:0] frac);
    beat_t b;
    b.command = CMD_DRAW;
    b.bin_index = BIN_F_W'($urandom);
    b.weight = WGT_F_W'($urandom);
    b.random_fraction = frac;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // wait for every beat to be taken and every draw answered
  task automatic settle();
    while (beats_taken != beats_queued || predicted_bins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_active_bins(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_cfg = value;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (held_beat.command == CMD_WRITE) begin
          weight_table[held_beat.bin_index] = held_beat.weight;
        end else begin
          predicted_bins.push_back(roulette_pick(held_beat.random_fraction));
        end
        beats_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_beats.size() != 0 && (no_stall || $urandom_range(99) >= 25)) begin
          held_beat = pending_beats.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.command <= held_beat.command;
          in_bus.bin_index <= held_beat.bin_index;
          in_bus.weight <= held_beat.weight;
          in_bus.random_fraction <= held_beat.random_fraction;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (predicted_bins.size() == 0) begin
          $error("selected_bin: expected none, actual %0d", out_bus.selected_bin);
          failures++;
        end else begin
          due_bin = predicted_bins.pop_front();
          if (out_bus.selected_bin !== due_bin) begin
            $error("selected_bin: expected %0d, actual %0d", due_bin, out_bus.selected_bin);
            failures++;
          end
        end
      end
      out_bus.ready <= no_stall || $urandom_range(99) >= 25;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0]   cfg_plan [10];
    int unsigned        live;
    int unsigned        phase;
    int unsigned        k;
    int unsigned        j;
    int unsigned        r;
    logic [BIN_F_W-1:0] idx;
    logic [WGT_F_W-1:0] w;
    logic [FRAC_W-1:0]  f;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.command = CMD_WRITE;
    in_bus.bin_index = '0;
    in_bus.weight = '0;
    in_bus.random_fraction = '0;
    out_bus.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: one bin, all weights zero
    queue_draw('0);
    queue_write(BIN_F_W'(0), '1);
    queue_draw('1);
    settle();

    set_active_bins(CFG_W'(BINS));
    queue_draw('1);
    queue_write('1, '1);
    queue_write(BIN_F_W'(32), WGT_F_W'(1));
    queue_draw('0);
    queue_draw('1);
    queue_draw(FRAC_W'(16'h8000));
    queue_write(BIN_F_W'(0), '0);
    queue_write(BIN_F_W'(21), WGT_F_W'(16'h5555));
    queue_write(BIN_F_W'(42), WGT_F_W'(16'haaaa));
    queue_draw(FRAC_W'(16'h5555));
    queue_draw(FRAC_W'(16'haaaa));
    queue_draw('1);
    queue_write('1, '0);
    queue_write(BIN_F_W'(32), '0);
    queue_write(BIN_F_W'(21), '0);
    queue_write(BIN_F_W'(42), '0);
    // all active weights zero: last bin
    queue_draw(FRAC_W'(16'h1234));
    queue_draw('1);
    settle();

    cfg_plan[0] = CFG_W'(0);
    cfg_plan[1] = '1;
    cfg_plan[2] = CFG_W'(BINS + 1);
    cfg_plan[3] = CFG_W'(2);
    cfg_plan[4] = CFG_W'(BINS);
    cfg_plan[5] = CFG_W'($urandom_range(63, 3));
    cfg_plan[6] = CFG_W'($urandom_range(127));
    cfg_plan[7] = CFG_W'($urandom_range(BINS, 1));
    cfg_plan[8] = CFG_W'(1);
    cfg_plan[9] = CFG_W'($urandom_range(127));

    for (phase = 0; phase < 10; phase++) begin
      set_active_bins(cfg_plan[phase]);
      no_stall = (phase == 4);
      live = live_bins();
      // beat budget per phase, clearing bursts included
      k = beats_queued + 93;
      while (beats_queued < k) begin
        r = $urandom_range(99);
        if (r < 3) begin
          for (j = 0; j < live; j++) queue_write(BIN_F_W'(j), '0);
        end else if (r < 48) begin
          idx = ($urandom_range(99) < 70) ? BIN_F_W'($urandom_range(live - 1))
                                          : BIN_F_W'($urandom);
          case ($urandom_range(9))
            0, 1:    w = '0;
            2:       w = '1;
            3, 4, 5: w = WGT_F_W'($urandom_range(15));
            default: w = WGT_F_W'($urandom);
          endcase
          queue_write(idx, w);
        end else begin
          case ($urandom_range(9))
            0:       f = '0;
            1:       f = '1;
            default: f = FRAC_W'($urandom);
          endcase
          queue_draw(f);
        end
      end
      settle();
    end
    no_stall = 1'b0;

    repeat (140) @(posedge clk);
    if (failures == 0) begin
      $display("weighted_bin_selection_core verification clean");
    end else begin
      $display("weighted_bin_selection_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("weighted_bin_selection_core verification failed");
    $finish;
  end

endmodule

[sim.f]
src/wbs_pkg.sv
src/wbs_if.sv
src/wbs_ram.sv
src/wbs_engine.sv
src/weighted_bin_selection_core.sv
bench/tb.sv
